>>> design/ghsa_pkg.sv
// Shared types and constants for the generation handle slot allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ghsa_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int GEN_SHIFT_DEF  = 12;

    // Fixed field widths of the item formats.
    localparam int CMD_W      = 2;
    localparam int ERR_W      = 2;
    localparam int HANDLE_W   = 31;
    localparam int SLOT_IO_W  = 10;
    localparam int RUNS_W     = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = OUT_DATA_W - (SLOT_IO_W + HANDLE_W + 1 + RUNS_W);

    // Width used to compare a slot number against the table size (up to 4096).
    localparam int RANGE_W = 13;

    // Input tdata bit offsets.
    localparam int IN_HANDLE_LSB = 0;
    localparam int IN_SLOT_LSB   = IN_HANDLE_LSB + HANDLE_W;
    localparam int IN_PARENT_LSB = IN_SLOT_LSB + SLOT_IO_W;
    localparam int IN_CHECK_BIT  = IN_PARENT_LSB + HANDLE_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_RUN    = 2'd3
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_BAD_HANDLE = 2'd1,
        ERR_NO_SLOT    = 2'd2
    } err_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;  // latch the item and read the slot memories
        logic commit;   // update the table and load the result register
    } ghsa_ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_room; // result register is empty or being drained
    } ghsa_stat_t;

endpackage

`default_nettype wire

>>> design/generation_handle_slot_allocator.sv
// Generation handle slot allocator: a table of slots with a LIFO free list
// and generation-counted handles. Usage:
//   s_ channel takes one command item: s_tuser carries the command
//   (allocate, free, look up, run); s_tdata carries handle, slot, parent
//   handle and the parent check flag.
//   m_ channel returns exactly one result item per command: m_tuser carries
//   the error code, m_tdata the slot, handle, slot-present flag and run count.
//   An item passes through two states: one accepts it and reads the slot memories at
//   its slot, the other updates the table and loads the result register. The
//   next item is accepted in the cycle after that, so a new item is not taken
//   before the last one is through, owing to the single read and write port of the
//   slot memories.
//   m_tvalid rises at the clock edge that ends the update cycle, in which the
//   result register is loaded, unless the update cycle has to wait.
//   A result waiting in the output register does not block the next
//   acceptance; if it is still not taken when the next item finishes, that
//   item waits in its update cycle until m_tready frees the register.
//   Reset (aresetn low, synchronous) empties the result register and
//   restores an all-free table with no current slot. No clearing pass is
//   needed: a fill count marks the slots that were never allocated.
// Depends on ghsa_pkg, ghsa_ctrl and ghsa_dp.
`default_nettype none

module generation_handle_slot_allocator #(
    parameter int SLOT_COUNT = ghsa_pkg::SLOT_COUNT_DEF,
    parameter int GEN_SHIFT  = ghsa_pkg::GEN_SHIFT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata, from bit 0: handle_in[31], slot_in[10], parent_in[31],
    // check_parent[1], zero padding[7]
    input  wire logic [ghsa_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: cmd[2]
    input  wire logic [ghsa_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata, from bit 0: slot_out[10], handle_out[31], slot_present[1],
    // run_total[32], zero padding[6]
    output logic [ghsa_pkg::OUT_DATA_W-1:0]       m_tdata,
    // m_tuser: error_code[2]
    output logic [ghsa_pkg::ERR_W-1:0]            m_tuser
);

    ghsa_pkg::ghsa_ctrl_t ctrl;
    ghsa_pkg::ghsa_stat_t stat;
    ghsa_pkg::err_t       out_err;

    logic [ghsa_pkg::SLOT_IO_W-1:0] out_slot;
    logic [ghsa_pkg::HANDLE_W-1:0]  out_handle;
    logic                           out_present;
    logic [ghsa_pkg::RUNS_W-1:0]    out_runs;

    ghsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ghsa_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_SHIFT  (GEN_SHIFT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .stat        (stat),
        .cmd_in      (ghsa_pkg::cmd_t'(s_tuser)),
        .handle_in   (s_tdata[ghsa_pkg::IN_HANDLE_LSB +: ghsa_pkg::HANDLE_W]),
        .slot_in     (s_tdata[ghsa_pkg::IN_SLOT_LSB +: ghsa_pkg::SLOT_IO_W]),
        .parent_in   (s_tdata[ghsa_pkg::IN_PARENT_LSB +: ghsa_pkg::HANDLE_W]),
        .check_in    (s_tdata[ghsa_pkg::IN_CHECK_BIT]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_err     (out_err),
        .out_slot    (out_slot),
        .out_handle  (out_handle),
        .out_present (out_present),
        .out_runs    (out_runs)
    );

    assign m_tuser = out_err;
    assign m_tdata = {{ghsa_pkg::OUT_PAD_W{1'b0}}, out_runs, out_present, out_handle, out_slot};

endmodule

`default_nettype wire

>>> design/ghsa_ctrl.sv
// Controller for the generation handle slot allocator: a two-state sequencer.
// Depends on ghsa_pkg.
`default_nettype none

module ghsa_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ghsa_pkg::ghsa_stat_t stat,
    output ghsa_pkg::ghsa_ctrl_t    ctrl
);

    ghsa_pkg::state_t state_reg;
    ghsa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ghsa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ghsa_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = ghsa_pkg::ST_EXEC;
                end
            end
            ghsa_pkg::ST_EXEC: begin
                if (stat.out_room) begin
                    state_next = ghsa_pkg::ST_IDLE;
                end
            end
            default: state_next = ghsa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready     = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.commit  = 1'b0;
        unique case (state_reg)
            ghsa_pkg::ST_IDLE: begin
                // No item is taken while reset is held.
                in_ready     = aresetn;
                ctrl.capture = in_valid && aresetn;
            end
            ghsa_pkg::ST_EXEC: begin
                // Hold the item until the result register can take its result.
                ctrl.commit = stat.out_room;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/ghsa_dp.sv
// Datapath for the generation handle slot allocator: slot memories, free list
// head, current slot registers and the result register. Depends on ghsa_pkg.
`default_nettype none

module ghsa_dp #(
    parameter int SLOT_COUNT = ghsa_pkg::SLOT_COUNT_DEF,
    parameter int GEN_SHIFT  = ghsa_pkg::GEN_SHIFT_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ghsa_pkg::ghsa_ctrl_t            ctrl,
    output ghsa_pkg::ghsa_stat_t                 stat,
    input  wire ghsa_pkg::cmd_t                  cmd_in,
    input  wire logic [ghsa_pkg::HANDLE_W-1:0]   handle_in,
    input  wire logic [ghsa_pkg::SLOT_IO_W-1:0]  slot_in,
    input  wire logic [ghsa_pkg::HANDLE_W-1:0]   parent_in,
    input  wire logic                            check_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output ghsa_pkg::err_t                       out_err,
    output logic [ghsa_pkg::SLOT_IO_W-1:0]       out_slot,
    output logic [ghsa_pkg::HANDLE_W-1:0]        out_handle,
    output logic                                 out_present,
    output logic [ghsa_pkg::RUNS_W-1:0]          out_runs
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int HW     = ghsa_pkg::HANDLE_W;
    localparam int RW     = ghsa_pkg::RUNS_W;
    localparam logic [31:0] GEN_STEP  = 32'd1 << GEN_SHIFT;
    localparam logic [31:0] INDEX_CLR = ~(32'(SLOT_COUNT) - 32'd1);

    // Slot memories. The running/runnable distinction is not kept per slot:
    // only the current slot can be running, so a live bit is enough.
    logic              live_mem   [SLOT_COUNT];
    logic [HW-1:0]     handle_mem [SLOT_COUNT];
    logic [HW-1:0]     parent_mem [SLOT_COUNT];
    logic [RW-1:0]     runs_mem   [SLOT_COUNT];
    logic [SLOT_W:0]   next_mem   [SLOT_COUNT];

    // Registered read data.
    logic              rd_live_reg;
    logic [HW-1:0]     rd_handle_reg;
    logic [HW-1:0]     rd_parent_reg;
    logic [RW-1:0]     rd_runs_reg;
    logic [SLOT_W:0]   rd_next_reg;

    // Latched item.
    ghsa_pkg::cmd_t                 cmd_reg;
    logic [HW-1:0]                  handle_in_reg;
    logic [ghsa_pkg::SLOT_IO_W-1:0] slot_in_reg;
    logic [HW-1:0]                  parent_in_reg;
    logic                           check_reg;
    logic [SLOT_W-1:0]              addr_reg;

    // Table control state. Entries at or above the fill count were never
    // allocated, so they still read as free, handle zero and next entry i+1.
    logic [SLOT_W:0]   free_head_reg, free_head_next;
    logic [SLOT_W:0]   fill_reg, fill_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [HW-1:0]     cur_handle_reg, cur_handle_next;
    logic              out_valid_reg, out_valid_next;

    // Result register.
    ghsa_pkg::err_t                 res_err_reg;
    logic [ghsa_pkg::SLOT_IO_W-1:0] res_slot_reg;
    logic [HW-1:0]                  res_handle_reg;
    logic                           res_present_reg;
    logic [RW-1:0]                  res_runs_reg;

    logic [SLOT_W-1:0] rd_addr;

    logic              touched;
    logic              slot_live;
    logic              slot_bad;
    logic [HW-1:0]     old_handle;
    logic [SLOT_W:0]   old_next;
    logic [31:0]       gen_sum;
    logic [31:0]       gen_val;
    logic [HW-1:0]     new_handle;
    logic [RW-1:0]     runs_inc;

    logic              we_live, we_handle, we_parent, we_runs, we_next;
    logic              live_wdata;
    logic [RW-1:0]     runs_wdata;

    ghsa_pkg::err_t                 res_err;
    logic [ghsa_pkg::SLOT_IO_W-1:0] res_slot;
    logic [HW-1:0]                  res_handle;
    logic                           res_present;
    logic [RW-1:0]                  res_runs;

    // Read address for the item being accepted.
    always_comb begin
        case (cmd_in)
            ghsa_pkg::CMD_ALLOC:  rd_addr = free_head_reg[SLOT_W-1:0];
            ghsa_pkg::CMD_LOOKUP: rd_addr = handle_in[SLOT_W-1:0];
            default:              rd_addr = SLOT_W'(slot_in);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg       <= cmd_in;
            handle_in_reg <= handle_in;
            slot_in_reg   <= slot_in;
            parent_in_reg <= parent_in;
            check_reg     <= check_in;
            addr_reg      <= rd_addr;
            rd_live_reg   <= live_mem[rd_addr];
            rd_handle_reg <= handle_mem[rd_addr];
            rd_parent_reg <= parent_mem[rd_addr];
            rd_runs_reg   <= runs_mem[rd_addr];
            rd_next_reg   <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (we_live) begin
            live_mem[addr_reg] <= live_wdata;
        end
        if (we_handle) begin
            handle_mem[addr_reg] <= new_handle;
        end
        if (we_parent) begin
            parent_mem[addr_reg] <= parent_in_reg;
        end
        if (we_runs) begin
            runs_mem[addr_reg] <= runs_wdata;
        end
        if (we_next) begin
            next_mem[addr_reg] <= free_head_reg;
        end
    end

    assign touched    = ({1'b0, addr_reg} < fill_reg);
    assign slot_live  = touched && rd_live_reg;
    assign slot_bad   = ghsa_pkg::RANGE_W'(slot_in_reg) >= ghsa_pkg::RANGE_W'(SLOT_COUNT);
    assign old_handle = touched ? rd_handle_reg : '0;
    assign old_next   = touched ? rd_next_reg : ({1'b0, addr_reg} + (SLOT_W+1)'(1));
    assign runs_inc   = rd_runs_reg + RW'(1);

    // Next generation: step past the index bits, restart on zero or sign bit.
    always_comb begin
        gen_sum = {1'b0, old_handle} + GEN_STEP;
        gen_val = gen_sum & INDEX_CLR;
        if (gen_val == 32'd0 || gen_val[31]) begin
            gen_val = GEN_STEP;
        end
        new_handle = HW'(gen_val | 32'(addr_reg));
    end

    always_comb begin
        free_head_next  = free_head_reg;
        fill_next       = fill_reg;
        cur_slot_next   = cur_slot_reg;
        cur_valid_next  = cur_valid_reg;
        cur_handle_next = cur_handle_reg;
        we_live         = 1'b0;
        we_handle       = 1'b0;
        we_parent       = 1'b0;
        we_runs         = 1'b0;
        we_next         = 1'b0;
        live_wdata      = 1'b0;
        runs_wdata      = '0;
        res_err         = ghsa_pkg::ERR_OK;
        res_slot        = '0;
        res_handle      = '0;
        res_present     = 1'b0;
        res_runs        = '0;

        unique case (cmd_reg)
            ghsa_pkg::CMD_ALLOC: begin
                if (free_head_reg[SLOT_W]) begin
                    res_err = ghsa_pkg::ERR_NO_SLOT;
                end else begin
                    we_live        = ctrl.commit;
                    live_wdata     = 1'b1;
                    we_handle      = ctrl.commit;
                    we_parent      = ctrl.commit;
                    we_runs        = ctrl.commit;
                    free_head_next = old_next;
                    if (!touched) begin
                        fill_next = fill_reg + (SLOT_W+1)'(1);
                    end
                    // Keep the copy of the current slot's handle in step.
                    if (addr_reg == cur_slot_reg) begin
                        cur_handle_next = new_handle;
                    end
                    res_slot    = ghsa_pkg::SLOT_IO_W'(addr_reg);
                    res_handle  = new_handle;
                    res_present = 1'b1;
                end
            end
            ghsa_pkg::CMD_FREE: begin
                if (slot_bad || !slot_live) begin
                    res_err = ghsa_pkg::ERR_BAD_HANDLE;
                end else begin
                    we_live        = ctrl.commit;
                    live_wdata     = 1'b0;
                    we_next        = ctrl.commit;
                    free_head_next = {1'b0, addr_reg};
                    res_slot       = ghsa_pkg::SLOT_IO_W'(addr_reg);
                    res_handle     = rd_handle_reg;
                    res_present    = 1'b1;
                end
            end
            ghsa_pkg::CMD_LOOKUP: begin
                if (handle_in_reg == '0) begin
                    res_present = cur_valid_reg;
                    if (cur_valid_reg) begin
                        res_slot   = ghsa_pkg::SLOT_IO_W'(cur_slot_reg);
                        res_handle = cur_handle_reg;
                    end
                end else if (!slot_live || rd_handle_reg != handle_in_reg) begin
                    res_err = ghsa_pkg::ERR_BAD_HANDLE;
                end else if (check_reg && (!cur_valid_reg ||
                             (addr_reg != cur_slot_reg &&
                              rd_parent_reg != cur_handle_reg))) begin
                    res_err = ghsa_pkg::ERR_BAD_HANDLE;
                end else begin
                    res_slot    = ghsa_pkg::SLOT_IO_W'(addr_reg);
                    res_handle  = handle_in_reg;
                    res_present = 1'b1;
                end
            end
            ghsa_pkg::CMD_RUN: begin
                if (slot_bad || !slot_live) begin
                    res_err = ghsa_pkg::ERR_BAD_HANDLE;
                end else begin
                    we_runs         = ctrl.commit;
                    runs_wdata      = runs_inc;
                    cur_slot_next   = addr_reg;
                    cur_valid_next  = 1'b1;
                    cur_handle_next = rd_handle_reg;
                    res_slot        = ghsa_pkg::SLOT_IO_W'(addr_reg);
                    res_handle      = rd_handle_reg;
                    res_present     = 1'b1;
                    res_runs        = runs_inc;
                end
            end
            default: res_err = ghsa_pkg::ERR_OK;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (ctrl.commit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= '0;
            fill_reg       <= '0;
            cur_slot_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            cur_handle_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (ctrl.commit) begin
                free_head_reg  <= free_head_next;
                fill_reg       <= fill_next;
                cur_slot_reg   <= cur_slot_next;
                cur_valid_reg  <= cur_valid_next;
                cur_handle_reg <= cur_handle_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            res_err_reg     <= res_err;
            res_slot_reg    <= res_slot;
            res_handle_reg  <= res_handle;
            res_present_reg <= res_present;
            res_runs_reg    <= res_runs;
        end
    end

    assign stat.out_room = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_err       = res_err_reg;
    assign out_slot      = res_slot_reg;
    assign out_handle    = res_handle_reg;
    assign out_present   = res_present_reg;
    assign out_runs      = res_runs_reg;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking bench for generation_handle_slot_allocator: directed and random command
// items with idle and stall gaps, checked against an in-bench model of the slot table.
// Depends on ghsa_pkg and the design sources under design/.
`default_nettype none

module testbench;

    localparam int SLOTS     = ghsa_pkg::SLOT_COUNT_DEF;
    localparam int GEN_SHIFT = ghsa_pkg::GEN_SHIFT_DEF;
    localparam int HANDLE_W  = ghsa_pkg::HANDLE_W;
    localparam int SLOT_IO_W = ghsa_pkg::SLOT_IO_W;
    localparam int RUNS_W    = ghsa_pkg::RUNS_W;

    localparam logic [1:0] SLOT_FREE    = 2'd0;
    localparam logic [1:0] SLOT_READY   = 2'd2;
    localparam logic [1:0] SLOT_RUNNING = 2'd3;

    // Result tdata layout, from bit 0.
    localparam int OUT_HANDLE_LSB  = SLOT_IO_W;
    localparam int OUT_PRESENT_BIT = OUT_HANDLE_LSB + HANDLE_W;
    localparam int OUT_RUNS_LSB    = OUT_PRESENT_BIT + 1;

    typedef struct packed {
        ghsa_pkg::cmd_t      cmd;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_IO_W-1:0] slot;
        logic [HANDLE_W-1:0] parent;
        logic                check;
    } table_cmd_t;

    typedef struct packed {
        ghsa_pkg::err_t       err;
        logic [SLOT_IO_W-1:0] slot;
        logic [HANDLE_W-1:0]  handle;
        logic                 present;
        logic [RUNS_W-1:0]    runs;
    } slot_reply_t;

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ghsa_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [ghsa_pkg::CMD_W-1:0]      s_tuser  = ghsa_pkg::CMD_ALLOC;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ghsa_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [ghsa_pkg::ERR_W-1:0]      m_tuser;

    generation_handle_slot_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Model of the slot table.
    logic [1:0]          life      [SLOTS];
    logic [HANDLE_W-1:0] tag       [SLOTS];
    logic [HANDLE_W-1:0] owner     [SLOTS];
    logic [RUNS_W-1:0]   run_count [SLOTS];
    logic [10:0]         link      [SLOTS];
    logic [10:0]         list_head;
    int unsigned         cur_slot;
    bit                  cur_live;

    table_cmd_t  pending_cmds [$];
    slot_reply_t replies_due  [$];
    table_cmd_t  in_flight;

    int unsigned mismatches = 0;
    int unsigned cmd_seen [4] = '{0, 0, 0, 0};
    int unsigned replies_seen = 0;
    int unsigned bad_seen = 0;
    int unsigned full_seen = 0;

    int unsigned tx_gap  = 0;
    bit          tx_calm = 1'b0;
    int unsigned rx_wait = 0;
    bit          rx_calm = 1'b0;

    function automatic slot_reply_t table_step(table_cmd_t it);
        slot_reply_t r;
        int unsigned idx;
        logic [31:0] gen;
        r = '0;
        r.err = ghsa_pkg::ERR_OK;
        case (it.cmd)
            ghsa_pkg::CMD_ALLOC: begin
                if (list_head >= SLOTS) begin
                    r.err = ghsa_pkg::ERR_NO_SLOT;
                end else begin
                    idx = 32'(list_head);
                    gen = ({1'b0, tag[idx]} + (32'd1 << GEN_SHIFT)) & ~(32'(SLOTS) - 32'd1);
                    // A generation that overflows restarts at the first one.
                    if (gen == 32'd0 || gen[31])
                        gen = 32'd1 << GEN_SHIFT;
                    gen = gen | idx;
                    tag[idx] = gen[HANDLE_W-1:0];
                    owner[idx] = it.parent;
                    life[idx] = SLOT_READY;
                    run_count[idx] = '0;
                    list_head = link[idx];
                    r.slot = SLOT_IO_W'(idx);
                    r.handle = tag[idx];
                    r.present = 1'b1;
                end
            end
            ghsa_pkg::CMD_FREE: begin
                if (life[it.slot] == SLOT_FREE) begin
                    r.err = ghsa_pkg::ERR_BAD_HANDLE;
                end else begin
                    life[it.slot] = SLOT_FREE;
                    link[it.slot] = list_head;
                    list_head = 11'(it.slot);
                    r.slot = it.slot;
                    r.handle = tag[it.slot];
                    r.present = 1'b1;
                end
            end
            ghsa_pkg::CMD_LOOKUP: begin
                if (it.handle == '0) begin
                    // Handle zero names the current slot, freed or not.
                    if (cur_live) begin
                        r.slot = SLOT_IO_W'(cur_slot);
                        r.handle = tag[cur_slot];
                        r.present = 1'b1;
                    end
                end else begin
                    idx = int'(it.handle) & (SLOTS - 1);
                    if (life[idx] == SLOT_FREE || tag[idx] != it.handle)
                        r.err = ghsa_pkg::ERR_BAD_HANDLE;
                    else if (it.check && (!cur_live ||
                             (idx != cur_slot && owner[idx] != tag[cur_slot])))
                        r.err = ghsa_pkg::ERR_BAD_HANDLE;
                    else begin
                        r.slot = SLOT_IO_W'(idx);
                        r.handle = it.handle;
                        r.present = 1'b1;
                    end
                end
            end
            default: begin
                if (life[it.slot] == SLOT_FREE) begin
                    r.err = ghsa_pkg::ERR_BAD_HANDLE;
                end else begin
                    if (cur_live && life[cur_slot] == SLOT_RUNNING)
                        life[cur_slot] = SLOT_READY;
                    cur_slot = 32'(it.slot);
                    cur_live = 1'b1;
                    life[it.slot] = SLOT_RUNNING;
                    run_count[it.slot] = run_count[it.slot] + 32'd1;
                    r.slot = it.slot;
                    r.handle = tag[it.slot];
                    r.present = 1'b1;
                    r.runs = run_count[it.slot];
                end
            end
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Random slot that is allocated (live) or free, or -1 if there is none.
    function automatic int pick_slot(bit live);
        int unsigned start;
        int unsigned s;
        start = $urandom_range(0, SLOTS - 1);
        for (int unsigned k = 0; k < SLOTS; k++) begin
            s = (start + k) % SLOTS;
            if ((life[s] != SLOT_FREE) == live)
                return int'(s);
        end
        return -1;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    task automatic push_cmd(ghsa_pkg::cmd_t c, logic [HANDLE_W-1:0] h,
                            logic [SLOT_IO_W-1:0] s, logic [HANDLE_W-1:0] p, bit chk);
        table_cmd_t it;
        it.cmd = c;
        it.handle = h;
        it.slot = s;
        it.parent = p;
        it.check = chk;
        pending_cmds.push_back(it);
    endtask

    // One random command; the mix is given as percentages, the rest are runs.
    // Slot and handle choices look at the model, which may trail by a few items.
    task automatic queue_random(int unsigned pa, int unsigned pf, int unsigned pl);
        table_cmd_t it;
        int unsigned r;
        int s;
        while (pending_cmds.size() >= 2)
            @(negedge aclk);
        it.cmd = ghsa_pkg::CMD_RUN;
        it.handle = HANDLE_W'($urandom);
        it.slot = SLOT_IO_W'($urandom);
        it.parent = HANDLE_W'($urandom);
        it.check = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < pa) begin
            it.cmd = ghsa_pkg::CMD_ALLOC;
            if (cur_live && $urandom_range(0, 1) == 1)
                it.parent = tag[cur_slot];
        end else if (r < pa + pf) begin
            it.cmd = ghsa_pkg::CMD_FREE;
            s = pick_slot(1'b1);
            if (s >= 0 && $urandom_range(0, 4) != 0)
                it.slot = SLOT_IO_W'(s);
        end else if (r < pa + pf + pl) begin
            it.cmd = ghsa_pkg::CMD_LOOKUP;
            r = $urandom_range(0, 9);
            if (r < 5) begin
                s = pick_slot(1'b1);
                if (s >= 0)
                    it.handle = tag[s];
            end else if (r == 5) begin
                it.handle = '0;
            end else if (r < 8) begin
                // Right index, wrong generation.
                s = pick_slot(1'b1);
                if (s >= 0)
                    it.handle = tag[s] ^ (HANDLE_W'(1) << $urandom_range(GEN_SHIFT, HANDLE_W - 1));
            end else if (r == 8) begin
                s = pick_slot(1'b0);
                if (s >= 0 && tag[s] != '0)
                    it.handle = tag[s];
            end
        end else begin
            s = pick_slot(1'b1);
            if (s >= 0 && $urandom_range(0, 5) != 0)
                it.slot = SLOT_IO_W'(s);
        end
        pending_cmds.push_back(it);
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Sender: holds each item until it is taken, with random gaps in between.
    always @(posedge aclk) begin
        int unsigned wait_left;
        bit taken;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            taken = s_tvalid && s_tready;
            wait_left = tx_gap;
            if (taken) begin
                replies_due.push_back(table_step(in_flight));
                cmd_seen[in_flight.cmd]++;
                wait_left = tx_calm ? 0 : idle_len();
                if ($urandom_range(0, 149) == 0)
                    tx_calm <= !tx_calm;
            end
            if (!s_tvalid || taken) begin
                if (wait_left == 0 && pending_cmds.size() != 0) begin
                    in_flight = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'b0, in_flight.check, in_flight.parent, in_flight.slot,
                                in_flight.handle};
                    s_tuser <= in_flight.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                    if (wait_left != 0)
                        wait_left--;
                end
                tx_gap <= wait_left;
            end
        end
    end

    // Receiver: stalls at random, independent of whether a result is waiting.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (rx_wait != 0) begin
                m_tready <= 1'b0;
                rx_wait <= rx_wait - 1;
            end else begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    rx_wait <= idle_len();
            end
            if ($urandom_range(0, 299) == 0)
                rx_calm <= !rx_calm;
        end
    end

    always @(posedge aclk) begin
        slot_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            if (m_tuser == ghsa_pkg::ERR_BAD_HANDLE)
                bad_seen++;
            if (m_tuser == ghsa_pkg::ERR_NO_SLOT)
                full_seen++;
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t: result item with none outstanding: tuser 0x%0h tdata 0x%0h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = replies_due.pop_front();
                check_field("error_code", want.err, m_tuser);
                check_field("slot_out", want.slot, m_tdata[SLOT_IO_W-1:0]);
                check_field("handle_out", want.handle,
                            m_tdata[OUT_HANDLE_LSB +: HANDLE_W]);
                check_field("slot_present", want.present, m_tdata[OUT_PRESENT_BIT]);
                check_field("run_total", want.runs, m_tdata[OUT_RUNS_LSB +: RUNS_W]);
            end
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            life[i] = SLOT_FREE;
            tag[i] = '0;
            owner[i] = '0;
            run_count[i] = '0;
            link[i] = 11'(i + 1);
        end
        list_head = '0;
        cur_slot = 0;
        cur_live = 1'b0;

        // Directed opening: empty table, first handles, parent checks, stale handles,
        // freeing the current slot and reuse of a freed slot.
        push_cmd(ghsa_pkg::CMD_LOOKUP, '0, '0, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, '0, '0, '0, 1'b1);
        push_cmd(ghsa_pkg::CMD_RUN, '0, 10'd5, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_FREE, '0, 10'd1023, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_ALLOC, '1, '1, 31'h7FFF_FFFF, 1'b1);
        push_cmd(ghsa_pkg::CMD_ALLOC, '0, '0, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h1000, '0, '0, 1'b1);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h1000, '0, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_RUN, '0, 10'd0, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h1001, '0, '0, 1'b1);
        push_cmd(ghsa_pkg::CMD_ALLOC, '0, '0, 31'h1000, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h1002, '0, '0, 1'b1);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h1000, '0, '0, 1'b1);
        push_cmd(ghsa_pkg::CMD_RUN, '0, 10'd1, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_RUN, '0, 10'd1, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h2000, '0, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h7FFF_FFFF, '0, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_FREE, '0, 10'd1, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, '0, '0, '0, 1'b1);
        push_cmd(ghsa_pkg::CMD_FREE, '0, 10'd1, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_RUN, '0, 10'd1, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_ALLOC, '0, '0, 31'h1001, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h1001, '0, '0, 1'b0);
        push_cmd(ghsa_pkg::CMD_LOOKUP, 31'h2001, '0, '0, 1'b1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        repeat (40)
            queue_random(35, 15, 30);
        // Fill the table until allocation is refused, then a few more refusals.
        while (list_head < SLOTS)
            queue_random(96, 0, 2);
        repeat (4)
            queue_random(100, 0, 0);
        // Free and reallocate so that slots come back with newer generations.
        repeat (40)
            queue_random(30, 35, 20);

        while (pending_cmds.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (replies_due.size() != 0)
            @(negedge aclk);
        repeat (10) @(posedge aclk);

        $display("Commands sent: %0d allocate, %0d free, %0d lookup, %0d run.",
                 cmd_seen[ghsa_pkg::CMD_ALLOC], cmd_seen[ghsa_pkg::CMD_FREE],
                 cmd_seen[ghsa_pkg::CMD_LOOKUP], cmd_seen[ghsa_pkg::CMD_RUN]);
        $display("Results checked: %0d, of them %0d bad handle and %0d table full.",
                 replies_seen, bad_seen, full_seen);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #24_000_000;
        $display("Timeout with %0d items queued and %0d results outstanding.",
                 pending_cmds.size(), replies_due.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
